FILE: hdl/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;

    // default widths of matrix entries and point components
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // fixed-point formats
    localparam int FRAC_COEF  = 12;
    localparam int FRAC_COORD = 16;

    // register and lane layout
    localparam int ROW_W    = 64;
    localparam int LANE_W   = 16;
    localparam int NUM_ROWS = 4;
    localparam int ADDR_W   = 5;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;

    // register indexes
    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } reg_idx_t;

    // identity matrix after reset
    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

    typedef logic [ROW_W-1:0] row_t;

endpackage
`default_nettype wire

FILE: hdl/vtpd_front.sv
`default_nettype none
module vtpd_front #(
    parameter int COEF_WIDTH  = vtpd_pkg::COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
    parameter int SUM_W       = COORD_WIDTH + COEF_WIDTH + 1
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire vtpd_pkg::row_t                  row0,
    input  wire vtpd_pkg::row_t                  row1,
    input  wire vtpd_pkg::row_t                  row2,
    input  wire vtpd_pkg::row_t                  row3,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire signed [COORD_WIDTH-1:0]         in_px,
    input  wire signed [COORD_WIDTH-1:0]         in_py,
    input  wire signed [COORD_WIDTH-1:0]         in_pz,
    output logic                                 push,
    input  wire                                  q_full,
    output logic [4*SUM_W-1:0]                   push_data
);
    import vtpd_pkg::*;

    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;

    logic                     en;
    logic signed [COEF_WIDTH-1:0] cf [0:3][0:3];
    logic                     prod_vld_reg, prod_vld_next;
    logic signed [PROD_W-1:0] prod_reg [0:3][0:2];
    logic signed [PROD_W-1:0] prod_next [0:3][0:2];
    logic signed [COEF_WIDTH-1:0] trans_reg [0:3];
    logic                     sum_vld_reg, sum_vld_next;
    logic signed [SUM_W-1:0]  sum_reg [0:3];
    logic signed [SUM_W-1:0]  sum_next [0:3];
    logic signed [COORD_WIDTH-1:0] pt [0:2];

    // matrix entries: low bits of each 16-bit lane
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            cf[0][c] = row0[LANE_W*c +: COEF_WIDTH];
            cf[1][c] = row1[LANE_W*c +: COEF_WIDTH];
            cf[2][c] = row2[LANE_W*c +: COEF_WIDTH];
            cf[3][c] = row3[LANE_W*c +: COEF_WIDTH];
        end
    end

    assign pt[0] = in_px;
    assign pt[1] = in_py;
    assign pt[2] = in_pz;

    // front pipeline moves unless the sum stage waits on a full queue
    assign en        = !(sum_vld_reg && q_full);
    assign in_ready  = en;
    assign push      = sum_vld_reg && !q_full;

    // stage 1: twelve products
    always_comb begin
        prod_vld_next = in_valid;
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[j][k] = PROD_W'(pt[k]) * PROD_W'(cf[k][j]);
            end
        end
    end

    // stage 2: column sums plus translation aligned to q.28
    always_comb begin
        sum_vld_next = prod_vld_reg;
        for (int j = 0; j < 4; j++) begin
            sum_next[j] = (SUM_W'(trans_reg[j]) <<< FRAC_COORD)
                        + SUM_W'(prod_reg[j][0]) + SUM_W'(prod_reg[j][1])
                        + SUM_W'(prod_reg[j][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else if (en) begin
            prod_vld_reg <= prod_vld_next;
            sum_vld_reg  <= sum_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[j][k] <= prod_next[j][k];
                end
                trans_reg[j] <= cf[3][j];
                sum_reg[j]   <= sum_next[j];
            end
        end
    end

    assign push_data = {sum_reg[3], sum_reg[2], sum_reg[1], sum_reg[0]};

endmodule
`default_nettype wire

FILE: hdl/vtpd_queue.sv
`default_nettype none
module vtpd_queue #(
    parameter int DATA_W = 8
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  wire [DATA_W-1:0]  wdata,
    output logic              full,
    input  wire               pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);
    import vtpd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    logic [DATA_W-1:0] mem [0:QDEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == (PTR_W+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/vtpd_back.sv
`default_nettype none
module vtpd_back #(
    parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
    parameter int SUM_W       = COORD_WIDTH + vtpd_pkg::COEF_WIDTH_DEF + 1
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire [4*SUM_W-1:0]  q_data,
    input  wire                q_empty,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [31:0]        out_qx,
    output logic [31:0]        out_qy,
    output logic [31:0]        out_qz,
    output logic               out_w_zero,
    output logic               out_overflow
);
    import vtpd_pkg::*;

    localparam int NST = COORD_WIDTH + 1;
    localparam int NW  = SUM_W + FRAC_COORD;

    logic en;

    // divider pipeline, stage 0 is setup, each later stage one quotient bit
    logic                   vld_reg  [0:NST-1];
    logic                   wz_reg   [0:NST-1];
    logic [SUM_W-1:0]       d_reg    [0:NST-1];
    logic [SUM_W-1:0]       r_reg    [0:NST-1][0:2];
    logic [COORD_WIDTH-1:0] q_reg    [0:NST-1][0:2];
    logic [COORD_WIDTH-1:0] nl_reg   [0:NST-1][0:2];
    logic                   neg_reg  [0:NST-1][0:2];
    logic                   psat_reg [0:NST-1][0:2];

    logic [SUM_W-1:0]       r_next  [0:NST-1][0:2];
    logic [COORD_WIDTH-1:0] q_next  [0:NST-1][0:2];
    logic [COORD_WIDTH-1:0] nl_next [0:NST-1][0:2];

    logic signed [SUM_W-1:0] s_in [0:3];
    logic [SUM_W-1:0]        mag  [0:3];
    logic [NW-1:0]           nfull [0:2];
    logic [SUM_W:0]          trial [1:NST-1][0:2];

    logic                         out_vld_reg;
    logic [31:0]                  out_q_reg [0:2];
    logic                         out_wz_reg, out_ovf_reg;
    logic signed [COORD_WIDTH-1:0] val [0:2];
    logic [2:0]                   sat;

    assign en  = !out_vld_reg || out_ready;
    assign pop = en && !q_empty;

    // setup: magnitudes, signs, early saturation test,
    // then one restoring division step per stage
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            s_in[l] = q_data[SUM_W*l +: SUM_W];
            mag[l]  = s_in[l][SUM_W-1] ? SUM_W'(-s_in[l]) : SUM_W'(s_in[l]);
        end
        for (int l = 0; l < 3; l++) begin
            nfull[l]      = {mag[l], {FRAC_COORD{1'b0}}};
            r_next[0][l]  = SUM_W'(nfull[l] >> COORD_WIDTH);
            nl_next[0][l] = nfull[l][COORD_WIDTH-1:0];
            q_next[0][l]  = '0;
        end
        for (int k = 1; k < NST; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial[k][l] = {r_reg[k-1][l], nl_reg[k-1][l][COORD_WIDTH-1]};
                if (trial[k][l] >= {1'b0, d_reg[k-1]}) begin
                    r_next[k][l] = SUM_W'(trial[k][l] - {1'b0, d_reg[k-1]});
                    q_next[k][l] = {q_reg[k-1][l][COORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_next[k][l] = trial[k][l][SUM_W-1:0];
                    q_next[k][l] = {q_reg[k-1][l][COORD_WIDTH-2:0], 1'b0};
                end
                nl_next[k][l] = nl_reg[k-1][l] << 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= !q_empty;
            for (int k = 1; k < NST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wz_reg[0] <= (s_in[3] == '0);
            d_reg[0]  <= mag[3];
            for (int l = 0; l < 3; l++) begin
                r_reg[0][l]    <= r_next[0][l];
                q_reg[0][l]    <= q_next[0][l];
                nl_reg[0][l]   <= nl_next[0][l];
                neg_reg[0][l]  <= s_in[l][SUM_W-1] ^ s_in[3][SUM_W-1];
                psat_reg[0][l] <= (r_next[0][l] >= mag[3]);
            end
            for (int k = 1; k < NST; k++) begin
                wz_reg[k] <= wz_reg[k-1];
                d_reg[k]  <= d_reg[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_reg[k][l]    <= r_next[k][l];
                    q_reg[k][l]    <= q_next[k][l];
                    nl_reg[k][l]   <= nl_next[k][l];
                    neg_reg[k][l]  <= neg_reg[k-1][l];
                    psat_reg[k][l] <= psat_reg[k-1][l];
                end
            end
        end
    end

    // saturation and sign of each quotient
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            sat[l] = psat_reg[NST-1][l]
                   || (neg_reg[NST-1][l] && q_reg[NST-1][l][COORD_WIDTH-1]
                       && (|q_reg[NST-1][l][COORD_WIDTH-2:0]))
                   || (!neg_reg[NST-1][l] && q_reg[NST-1][l][COORD_WIDTH-1]);
            if (wz_reg[NST-1]) begin
                val[l] = '0;
            end else if (sat[l]) begin
                val[l] = neg_reg[NST-1][l] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                           : {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end else begin
                val[l] = neg_reg[NST-1][l] ? -q_reg[NST-1][l] : q_reg[NST-1][l];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                out_q_reg[l] <= 32'(val[l]);
            end
            out_wz_reg  <= wz_reg[NST-1];
            out_ovf_reg <= !wz_reg[NST-1] && (|sat);
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_qx       = out_q_reg[0];
    assign out_qy       = out_q_reg[1];
    assign out_qz       = out_q_reg[2];
    assign out_w_zero   = out_wz_reg;
    assign out_overflow = out_ovf_reg;

endmodule
`default_nettype wire

FILE: hdl/vertex_transform_perspective_divide_core.sv
// Vertex transform with perspective divide.
// Input stream s_*: one point per transaction, tdata = px, py, pz (32 bits each,
// signed Q16.16). Output stream m_*: one result per transaction, tdata = qx,
// qy, qz (signed Q16.16, saturated), tuser = w_zero, overflow.
// The 4x4 matrix (rows of four Q4.12 entries) is written over the APB port at
// byte addresses 0, 8, 16, 24 and should only change while the block is idle.
// Throughput is one point per cycle while the result stream is not stalled.
// From input to output a point passes the product and sum stages, the queue,
// one setup stage, one restoring division step per quotient bit and the
// output register.
// A stalled receiver holds the output register and the divider pipeline; the
// four-entry queue absorbs the front stages, which stop taking points once it
// is full and the sum stage holds a point. Reset empties all stages and the
// queue and loads the identity matrix.
`default_nettype none
module vertex_transform_perspective_divide_core #(
    parameter int COEF_WIDTH  = vtpd_pkg::COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [95:0]                   s_tdata,   // px, py, pz
    // result stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [95:0]                  m_tdata,   // qx, qy, qz
    output logic [1:0]                   m_tuser,   // w_zero, overflow
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [vtpd_pkg::ADDR_W-1:0]   paddr,
    input  wire [vtpd_pkg::ROW_W-1:0]    pwdata,
    output logic [vtpd_pkg::ROW_W-1:0]   prdata,
    output logic                         pready
);
    import vtpd_pkg::*;

    localparam int SUM_W = COORD_WIDTH + COEF_WIDTH + 1;

    row_t             row_reg [0:NUM_ROWS-1];
    reg_idx_t         idx;
    logic             wr_en;
    logic             push, q_full, q_empty, pop;
    logic [4*SUM_W-1:0] push_data, q_data;

    // register file
    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign prdata = row_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[REG_ROW0] <= ROW0_RST;
            row_reg[REG_ROW1] <= ROW1_RST;
            row_reg[REG_ROW2] <= ROW2_RST;
            row_reg[REG_ROW3] <= ROW3_RST;
        end else if (wr_en) begin
            row_reg[idx] <= pwdata;
        end
    end

    vtpd_front #(
        .COEF_WIDTH  (COEF_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_W       (SUM_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row0      (row_reg[REG_ROW0]),
        .row1      (row_reg[REG_ROW1]),
        .row2      (row_reg[REG_ROW2]),
        .row3      (row_reg[REG_ROW3]),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_px     (s_tdata[COORD_WIDTH-1:0]),
        .in_py     (s_tdata[32 +: COORD_WIDTH]),
        .in_pz     (s_tdata[64 +: COORD_WIDTH]),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    vtpd_queue #(
        .DATA_W (4*SUM_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (push_data),
        .full    (q_full),
        .pop     (pop),
        .rdata   (q_data),
        .empty   (q_empty)
    );

    vtpd_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_W       (SUM_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_qx       (m_tdata[31:0]),
        .out_qy       (m_tdata[63:32]),
        .out_qz       (m_tdata[95:64]),
        .out_w_zero   (m_tuser[0]),
        .out_overflow (m_tuser[1])
    );

endmodule
`default_nettype wire

FILE: tb/sv/vertex_transform_perspective_divide_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_perspective_divide_core_tb;
    import vtpd_pkg::*;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
        logic        w_zero;
        logic        overflow;
    } vertex_out_t;

    localparam int LATENCY = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [ROW_W-1:0]  pwdata;
    logic [ROW_W-1:0]  prdata;
    logic        pready;

    // local copy of the matrix
    row_t matrix_rows [NUM_ROWS];

    logic [95:0]  point_queue [$];
    vertex_out_t  vertex_queue [$];
    logic         s_taken;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           mismatch_count;
    int           received_count;
    int           sent_count;

    vertex_transform_perspective_divide_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // one Q16.16 quotient, truncated and saturated
    function automatic logic [31:0] divide_q16(input logic signed [63:0] num,
                                               input logic signed [63:0] den,
                                               inout logic sat);
        logic        neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= 64'd65536) begin
            sat = 1'b1;
            mag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        end else begin
            for (int i = 0; i < FRAC_COORD; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 64'd1;
                end
            end
            mag = q;
            if (neg && mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
                sat = 1'b1;
            end
            if (!neg && mag > 64'h7FFF_FFFF) begin
                mag = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
        end
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    // transform one point by the current matrix
    function automatic vertex_out_t transform_vertex(input logic [95:0] pt);
        logic signed [63:0] p [3];
        logic signed [63:0] s [4];
        logic signed [15:0] c;
        logic               sat;
        vertex_out_t        res;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) p[k] = 64'(signed'(pt[32*k +: 32]));
        for (int j = 0; j < 4; j++) begin
            c = matrix_rows[3][16*j +: 16];
            s[j] = 64'(c) * 64'sd65536;
            for (int k = 0; k < 3; k++) begin
                c = matrix_rows[k][16*j +: 16];
                s[j] += p[k] * 64'(c);
            end
        end
        res = '0;
        if (s[3] == 0) begin
            res.w_zero = 1'b1;
        end else begin
            res.qx = divide_q16(s[0], s[3], sat);
            res.qy = divide_q16(s[1], s[3], sat);
            res.qz = divide_q16(s[2], s[3], sat);
            res.overflow = sat;
        end
        return res;
    endfunction

    // driver: predict on acceptance, then present next transaction
    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            vertex_queue.push_back(transform_vertex(s_tdata));
            sent_count <= sent_count + 1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_taken) begin
                if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= point_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        vertex_out_t got;
        vertex_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]};
            received_count <= received_count + 1;
            if (vertex_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = vertex_queue.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected qx=%h qy=%h qz=%h wz=%b ov=%b, got qx=%h qy=%h qz=%h wz=%b ov=%b",
                                 want.qx, want.qy, want.qz, want.w_zero, want.overflow,
                                 got.qx, got.qy, got.qz, got.w_zero, got.overflow);
                end
            end
        end
    end

    task automatic write_row(input reg_idx_t idx, input row_t value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx); pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        matrix_rows[idx] = value;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (point_queue.size() > 0 || s_tvalid || vertex_queue.size() > 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
            default: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef(input int mode);
        case (mode)
            0: return $urandom;
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic random_matrix(input int mode);
        row_t v;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < 4; c++) v[16*c +: 16] = rand_coef(mode);
            // keep w mostly positive and nonzero in the common mode
            if (mode != 0 && r == 3) v[63:48] = 16'($urandom_range(1024, 8192));
            write_row(reg_idx_t'(r), v);
        end
    endtask

    task automatic random_points(input int count, input int mode);
        for (int i = 0; i < count; i++)
            point_queue.push_back({rand_coord(mode), rand_coord(mode), rand_coord(mode)});
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0; s_taken = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatch_count = 0; received_count = 0; sent_count = 0;
        send_idle_pct = 20; recv_idle_pct = 62;
        matrix_rows[0] = ROW0_RST; matrix_rows[1] = ROW1_RST;
        matrix_rows[2] = ROW2_RST; matrix_rows[3] = ROW3_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: identity matrix with extreme coordinates
        point_queue.push_back('0);
        point_queue.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000});
        point_queue.push_back({32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000});
        point_queue.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF});
        wait_drained();

        // zero w from a zero last row and from a cancelling point
        write_row(REG_ROW3, 64'h0000_0000_0000_0000);
        point_queue.push_back({32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
        wait_drained();
        write_row(REG_ROW0, 64'h1000_0000_0000_1000);
        write_row(REG_ROW3, 64'hF000_0000_0000_0000);
        point_queue.push_back({32'h0, 32'h0, 32'h0001_0000});
        point_queue.push_back({32'h0, 32'h0, 32'h0000_8000});
        wait_drained();
        // tiny w translation forces truncation
        write_row(REG_ROW3, 64'h0001_0000_0000_0000);
        wait_drained();
        point_queue.push_back({32'h0, 32'hFFF0_0000, 32'h0010_0000});
        point_queue.push_back({32'h0, 32'h0, 32'h0000_0001});
        wait_drained();

        // extreme coefficients
        write_row(REG_ROW0, 64'h8000_7FFF_FFFF_8000);
        write_row(REG_ROW1, 64'h7FFF_8000_0001_FFFF);
        write_row(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_row(REG_ROW3, 64'h8000_7FFF_8000_7FFF);
        point_queue.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_queue.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        point_queue.push_back({32'h0003_0000, 32'hFFFD_0000, 32'h0000_4000});
        wait_drained();

        // random phases with changing idling
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin send_idle_pct = 62; recv_idle_pct = 20; end
            if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
            random_matrix(ph % 3 == 0 ? 0 : 1);
            random_points(130, ph % 3);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: vertex_transform_perspective_divide_core.f
hdl/vtpd_pkg.sv
hdl/vtpd_front.sv
hdl/vtpd_queue.sv
hdl/vtpd_back.sv
hdl/vertex_transform_perspective_divide_core.sv
tb/sv/vertex_transform_perspective_divide_core_tb.sv
